// ===== hw/rtl/sis_pkg.sv =====
`default_nettype none

package sis_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;

    localparam logic signed [KEY_W-1:0] TAIL_KEY = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
    } sis_ctrl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } sis_flag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sis_cell.sv =====
`default_nettype none

module sis_cell (
    input  wire  logic                               clk,
    input  wire  sis_pkg::sis_ctrl_t                 ctrl,
    input  wire  logic                               occ,
    input  wire  logic signed [sis_pkg::KEY_W-1:0]   op_key,
    input  wire  logic signed [sis_pkg::KEY_W-1:0]   prev_key,
    input  wire  logic                               prev_lt,
    input  wire  logic signed [sis_pkg::KEY_W-1:0]   next_key,
    output logic signed [sis_pkg::KEY_W-1:0]         key,
    output sis_pkg::sis_flag_t                       flag
);

    logic signed [sis_pkg::KEY_W-1:0] key_reg;
    logic signed [sis_pkg::KEY_W-1:0] key_next;
    sis_pkg::sis_flag_t               flag_reg;
    sis_pkg::sis_flag_t               flag_next;

    always_comb
    begin
        flag_next.lt = occ && (key_reg < op_key);
        flag_next.eq = occ && (key_reg == op_key);
    end

    // insert: cells at or past the slot take from the left; remove: from the right
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins_en && !flag_reg.lt)
        begin
            key_next = prev_lt ? op_key : prev_key;
        end
        else if (ctrl.del_en && !flag_reg.lt)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctrl.cmp_en)
        begin
            flag_reg <= flag_next;
        end
    end

    assign key  = key_reg;
    assign flag = flag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_integer_set.sv =====
// An accepted transaction passes the compare state, then the shift state,
// before its result is registered on m_tdata. The next transaction is taken
// only once the last has left the accept, compare and shift states that every
// cell of the key chain goes through per item; a result still waiting on
// m_tready holds the shift state. The output register holds a result while
// the next transaction is taken. Reset (rst_n low, asynchronous) empties the
// set and clears control state; the key cells themselves are not cleared.
`default_nettype none

module sorted_integer_set (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [39:0] s_tdata,   // [1:0] operation, [33:2] key, [39:34] zero
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [7:0]        m_tdata    // [0] success, [1] full_reject, [7:2] zero
);

    localparam int N     = sis_pkg::CAPACITY;
    localparam int CNT_W = sis_pkg::CNT_W;
    localparam int KEY_W = sis_pkg::KEY_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [1:0]              op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_tvalid_reg;
    logic                    success_reg;
    logic                    reject_reg;

    sis_pkg::sis_ctrl_t      ctrl;
    logic signed [KEY_W-1:0] cell_key [N];
    sis_pkg::sis_flag_t      cell_flag [N];
    logic [N-1:0]            eq_vec;

    logic out_free;
    logic accept;
    logic found;
    logic is_tail;
    logic full;
    logic do_exec;
    logic res_ok;
    logic res_rej;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign do_exec  = (state_reg == ST_EXEC) && out_free;
    assign found    = |eq_vec;
    assign is_tail  = (key_reg == sis_pkg::TAIL_KEY);
    assign full     = (count_reg == CNT_W'(N));

    always_comb
    begin
        res_ok  = 1'b0;
        res_rej = 1'b0;
        case (op_reg)
            sis_pkg::OP_ADD:
            begin
                res_ok  = !is_tail && !found && !full;
                res_rej = !is_tail && !found && full;
            end
            sis_pkg::OP_REMOVE:
            begin
                res_ok = !is_tail && found;
            end
            sis_pkg::OP_CONTAINS:
            begin
                res_ok = is_tail || found;
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ctrl.cmp_en = (state_reg == ST_CMP);
        ctrl.ins_en = do_exec && (op_reg == sis_pkg::OP_ADD) && res_ok;
        ctrl.del_en = do_exec && (op_reg == sis_pkg::OP_REMOVE) && res_ok;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.del_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic signed [KEY_W-1:0] prev_key;
            logic signed [KEY_W-1:0] next_key;
            logic                    prev_lt;
            logic                    occ;

            if (gi == 0)
            begin : g_first
                assign prev_key = key_reg;
                assign prev_lt  = 1'b0;
            end
            else
            begin : g_mid
                assign prev_key = cell_key[gi-1];
                assign prev_lt  = cell_flag[gi-1].lt;
            end

            if (gi == N - 1)
            begin : g_last
                assign next_key = cell_key[gi];
            end
            else
            begin : g_inner
                assign next_key = cell_key[gi+1];
            end

            assign occ        = (CNT_W'(gi) < count_reg);
            assign eq_vec[gi] = cell_flag[gi].eq;

            sis_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occ      (occ),
                .op_key   (key_reg),
                .prev_key (prev_key),
                .prev_lt  (prev_lt),
                .next_key (next_key),
                .key      (cell_key[gi]),
                .flag     (cell_flag[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (do_exec)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
        end
        if (do_exec)
        begin
            success_reg <= res_ok;
            reject_reg  <= res_rej;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, reject_reg, success_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("set count above capacity");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("success and full_reject both set");

    a_count_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_EXEC))
        else $error("count changed outside the shift cycle");

    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CMP && !s_tready))
        else $error("accepted transaction did not enter compare");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sis_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] MIN_KEY = 32'sh8000_0000;
    localparam int POOL_SIZE      = 96;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct packed {
        logic full_reject;
        logic success;
    } set_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    logic signed [KEY_W-1:0] set_keys[$];
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
    set_result_t             expected_results[$];
    int                      mismatch_count = 0;
    int                      stall_cycles = 0;
    bit                      src_idle_en = 1'b0;
    bit                      sink_idle_en = 1'b0;
    bit                      sink_hold_req = 1'b0;

    sorted_integer_set dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic set_result_t predict_set_op(input logic [1:0] op,
                                                   input logic signed [KEY_W-1:0] key);
        set_result_t res;
        int          pos;
        bit          hit;
        res = '0;
        pos = 0;
        while (pos < set_keys.size() && set_keys[pos] < key)
            pos++;
        hit = (pos < set_keys.size()) && (set_keys[pos] == key);
        case (op)
            OP_ADD:
            begin
                if (key != TAIL_KEY && !hit)
                begin
                    if (set_keys.size() >= CAPACITY)
                        res.full_reject = 1'b1;
                    else
                    begin
                        set_keys.insert(pos, key);
                        res.success = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (key != TAIL_KEY && hit)
                begin
                    set_keys.delete(pos);
                    res.success = 1'b1;
                end
            end
            OP_CONTAINS:
                res.success = (key == TAIL_KEY) || hit;
            default:
                res = '0;
        endcase
        return res;
    endfunction

    // predict on input transactions, then check output transactions
    always @(posedge clk)
    begin
        set_result_t got;
        set_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_set_op(s_tdata[1:0], s_tdata[33:2]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[1:0];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %b", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.success !== want.success)
                    begin
                        $display("%0t: success mismatch: expected %b, actual %b",
                                 $time, want.success, got.success);
                        mismatch_count++;
                    end
                    if (got.full_reject !== want.full_reject)
                    begin
                        $display("%0t: full_reject mismatch: expected %b, actual %b",
                                 $time, want.full_reject, got.full_reject);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("** sorted_integer_set: FAILED **");
        $finish;
    end

    // result side: random stalls, or one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic signed [KEY_W-1:0] key);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, key, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_ADD;
        else if (r < 70)
            return OP_REMOVE;
        else if (r < 95)
            return OP_CONTAINS;
        return OP_UNUSED;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 84)
            return TAIL_KEY;
        return $urandom;
    endfunction

    task automatic build_key_pool();
        logic signed [KEY_W-1:0] k;
        bit dup;
        key_pool[0] = MIN_KEY;
        key_pool[1] = -32'sd1;
        key_pool[2] = 32'sd0;
        key_pool[3] = 32'sd1;
        key_pool[4] = TAIL_KEY - 1;
        for (int i = 5; i < POOL_SIZE; i++)
        begin
            do
            begin
                k = (i % 2) ? $signed($urandom) : $signed(32'($urandom_range(0, 200)) - 100);
                dup = (k == TAIL_KEY);
                for (int j = 0; j < i; j++)
                    if (key_pool[j] == k)
                        dup = 1'b1;
            end
            while (dup);
            key_pool[i] = k;
        end
    endtask

    task automatic test_directed();
        send_item(OP_CONTAINS, MIN_KEY);
        send_item(OP_ADD, MIN_KEY);
        send_item(OP_ADD, MIN_KEY);
        send_item(OP_CONTAINS, MIN_KEY);
        send_item(OP_ADD, TAIL_KEY);
        send_item(OP_CONTAINS, TAIL_KEY);
        send_item(OP_REMOVE, TAIL_KEY);
        send_item(OP_ADD, -32'sd1);
        send_item(OP_ADD, 32'sd0);
        send_item(OP_ADD, 32'sd1);
        send_item(OP_ADD, TAIL_KEY - 1);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_REMOVE, 32'sd0);
        send_item(OP_CONTAINS, 32'sd1);
        send_item(OP_CONTAINS, 32'sd0);
        send_item(OP_UNUSED, MIN_KEY);
        send_item(OP_UNUSED, TAIL_KEY);
        send_item(OP_REMOVE, MIN_KEY);
        send_item(OP_REMOVE, -32'sd1);
        send_item(OP_REMOVE, 32'sd1);
        send_item(OP_REMOVE, TAIL_KEY - 1);
        send_item(OP_CONTAINS, TAIL_KEY - 1);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < CAPACITY; i++)
            send_item(OP_ADD, key_pool[i]);
        send_item(OP_ADD, key_pool[CAPACITY]);
        send_item(OP_ADD, key_pool[0]);
        send_item(OP_ADD, TAIL_KEY);
        send_item(OP_CONTAINS, key_pool[CAPACITY]);
        send_item(OP_CONTAINS, key_pool[CAPACITY - 1]);
        send_item(OP_REMOVE, key_pool[10]);
        send_item(OP_ADD, key_pool[CAPACITY]);
        send_item(OP_ADD, key_pool[CAPACITY + 1]);
    endtask

    task automatic test_backpressure();
        src_idle_en   = 1'b0;
        sink_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(pick_op(), pick_key());
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                src_idle_en  = $urandom_range(0, 1);
                sink_idle_en = $urandom_range(0, 1);
            end
            send_item(pick_op(), pick_key());
        end
    endtask

    task automatic test_streaming(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int i = 0; i < count; i++)
            send_item(pick_op(), pick_key());
    endtask

    initial
    begin
        build_key_pool();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random(340);
        test_streaming(80);

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** sorted_integer_set: PASSED **");
        else
            $display("** sorted_integer_set: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/sis_pkg.sv
hw/rtl/sis_cell.sv
hw/rtl/sorted_integer_set.sv
verif/tb_top.sv
